// ----- hdl/trp_pkg.sv -----
// Shared types and constants for the trie root replacer.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package trp_pkg;

  // Default sizing of the node pool and the alphabet.
  localparam int NODES_DEF    = 1024;
  localparam int ALPHABET_DEF = 26;

  // Depth of the queue between the front and the back end (power of two).
  localparam int QUEUE_DEPTH = 4;

  // Input kind codes.
  localparam logic [1:0] KIND_DICT  = 2'd0;
  localparam logic [1:0] KIND_SENT  = 2'd1;
  localparam logic [1:0] KIND_SPACE = 2'd2;
  localparam logic [1:0] KIND_EOS   = 2'd3;

  // Symbol emitted for a space.
  localparam logic [4:0] SPACE_SYMBOL = 5'd26;

  // One input beat.
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] letter;
    logic       root_end;
  } trp_in_t;

  // One result beat.
  typedef struct packed {
    logic [4:0] symbol;
    logic       pool_overflowed;
  } trp_out_t;

  // Operation decoded by the front end.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MATCH,
    OP_SPACE,
    OP_EOS
  } trp_op_t;

  // Queued command.
  typedef struct packed {
    trp_op_t    op;
    logic [4:0] letter;
    logic       root_end;
  } trp_cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    trp_cmd_t cmd;
  } trp_head_t;

  // Matching mode of the current sentence word.
  typedef enum logic [1:0] {
    MM_MATCH,
    MM_ECHO,
    MM_SUPPRESS
  } trp_mode_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BE_CLEAR,
    BE_READ,
    BE_EXEC
  } trp_be_state_t;

endpackage

`default_nettype wire

// ----- hdl/trp_front.sv -----
// Front end of the trie root replacer: accepts input beats, decodes the kind
// into an operation and queues the commands. Depends on trp_pkg.
`default_nettype none

module trp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire trp_pkg::trp_in_t  in_data,
  input  wire logic              accept_en,
  output trp_pkg::trp_head_t     head,
  input  wire logic              head_pop
);
  import trp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  trp_cmd_t         q_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  trp_cmd_t         cmd_in;
  logic             push;

  // Decode the input kind into a back-end operation.
  always_comb begin
    cmd_in.letter   = in_data.letter;
    cmd_in.root_end = in_data.root_end;
    unique case (in_data.kind)
      KIND_DICT:  cmd_in.op = OP_LOAD;
      KIND_SENT:  cmd_in.op = OP_MATCH;
      KIND_SPACE: cmd_in.op = OP_SPACE;
      KIND_EOS:   cmd_in.op = OP_EOS;
      default:    cmd_in.op = OP_EOS;
    endcase
  end

  // Accept while there is room and the back end is not clearing its memory.
  assign in_ready = accept_en && (count_r != (PW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = head_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(push) - (PW+1)'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- hdl/trp_back.sv -----
// Back end of the trie root replacer: child-pointer memory, load and match
// cursors, read/execute sequencer and the result register.
// Depends on trp_pkg.
`default_nettype none

module trp_back #(
  parameter int NODES    = trp_pkg::NODES_DEF,
  parameter int ALPHABET = trp_pkg::ALPHABET_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire trp_pkg::trp_head_t head,
  output logic                    head_pop,
  output logic                    clr_busy,
  output logic                    ovf_flag,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output trp_pkg::trp_out_t       out_data
);
  import trp_pkg::*;

  localparam int CW    = $clog2(NODES);
  localparam int DEPTH = NODES * ALPHABET;
  localparam int AW    = $clog2(DEPTH);

  // Each entry holds a child pointer and the terminal mark of that child.
  logic [CW:0]      mem [DEPTH];

  trp_be_state_t    state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r;
  logic [CW:0]      rd_data_r;
  logic [AW-1:0]    slot_r;
  logic [CW-1:0]    load_cur_r, load_cur_nxt;
  logic [CW-1:0]    match_cur_r, match_cur_nxt;
  logic             drop_r, drop_nxt;
  trp_mode_t        mode_r, mode_nxt;
  logic [CW:0]      free_r, free_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r;
  trp_out_t         out_data_r;

  logic [CW-1:0]    cur_sel;
  logic [AW-1:0]    rd_addr;
  logic             letter_ok;
  logic [CW-1:0]    ent_ptr;
  logic             ent_term;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CW:0]      mem_wdata;
  logic             mem_re;
  logic             upd_we;
  logic [CW:0]      upd_wdata;
  logic             emit_want;
  logic [4:0]       emit_sym;
  logic             slot_free;
  logic             fire;

  // Slot address of the current command: cursor times alphabet plus letter.
  assign cur_sel   = (head.cmd.op == OP_LOAD) ? load_cur_r : match_cur_r;
  assign rd_addr   = AW'(cur_sel) * AW'(ALPHABET) + AW'(head.cmd.letter);
  assign letter_ok = (32'(head.cmd.letter) < ALPHABET);
  assign ent_ptr   = rd_data_r[CW-1:0];
  assign ent_term  = rd_data_r[CW];

  // Result register frees up when empty or being taken.
  assign slot_free = !out_valid_r || out_ready;
  assign fire      = (state_r == BE_EXEC) && (!emit_want || slot_free);

  // Execute step: trie update for dictionary letters, match walk for sentence beats.
  always_comb begin
    load_cur_nxt  = load_cur_r;
    match_cur_nxt = match_cur_r;
    drop_nxt      = drop_r;
    mode_nxt      = mode_r;
    free_nxt      = free_r;
    ovf_nxt       = ovf_r;
    upd_we        = 1'b0;
    upd_wdata     = rd_data_r;
    emit_want     = 1'b0;
    emit_sym      = head.cmd.letter;
    unique case (head.cmd.op)
      OP_LOAD: begin
        if (!drop_r) begin
          if (!letter_ok) begin
            drop_nxt = 1'b1;
          end else if (ent_ptr == '0) begin
            if (free_r == (CW+1)'(NODES)) begin
              ovf_nxt  = 1'b1;
              drop_nxt = 1'b1;
            end else begin
              upd_we       = 1'b1;
              upd_wdata    = {head.cmd.root_end, free_r[CW-1:0]};
              load_cur_nxt = free_r[CW-1:0];
              free_nxt     = free_r + 1'b1;
            end
          end else begin
            load_cur_nxt = ent_ptr;
            if (head.cmd.root_end) begin
              upd_we    = 1'b1;
              upd_wdata = {1'b1, ent_ptr};
            end
          end
        end
        if (head.cmd.root_end) begin
          load_cur_nxt = '0;
          drop_nxt     = 1'b0;
        end
      end
      OP_MATCH: begin
        emit_want = (mode_r != MM_SUPPRESS);
        if (mode_r == MM_MATCH) begin
          if (!letter_ok || ent_ptr == '0) begin
            mode_nxt = MM_ECHO;
          end else begin
            match_cur_nxt = ent_ptr;
            if (ent_term) begin
              mode_nxt = MM_SUPPRESS;
            end
          end
        end
      end
      OP_SPACE: begin
        match_cur_nxt = '0;
        mode_nxt      = MM_MATCH;
        emit_want     = 1'b1;
        emit_sym      = SPACE_SYMBOL;
      end
      OP_EOS: begin
        match_cur_nxt = '0;
        mode_nxt      = MM_MATCH;
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_CLEAR: if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = BE_READ;
      BE_READ:  if (head.valid) state_nxt = BE_EXEC;
      BE_EXEC:  if (fire) state_nxt = BE_READ;
      default:  state_nxt = BE_CLEAR;
    endcase
  end

  // Sequencer outputs: memory port control and queue pop.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = upd_wdata;
    mem_re    = 1'b0;
    head_pop  = 1'b0;
    clr_busy  = 1'b0;
    unique case (state_r)
      BE_CLEAR: begin
        clr_busy  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      BE_READ: begin
        mem_re = head.valid && letter_ok;
      end
      BE_EXEC: begin
        mem_we   = upd_we && fire;
        head_pop = fire;
      end
      default: begin
        clr_busy = 1'b0;
      end
    endcase
  end

  // Child-pointer memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Slot address kept for the write-back in the execute cycle.
  always_ff @(posedge clk) begin
    if (state_r == BE_READ) begin
      slot_r <= rd_addr;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_CLEAR;
      clr_addr_r  <= '0;
      load_cur_r  <= '0;
      match_cur_r <= '0;
      drop_r      <= 1'b0;
      mode_r      <= MM_MATCH;
      free_r      <= (CW+1)'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BE_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (fire) begin
        load_cur_r  <= load_cur_nxt;
        match_cur_r <= match_cur_nxt;
        drop_r      <= drop_nxt;
        mode_r      <= mode_nxt;
        free_r      <= free_nxt;
        ovf_r       <= ovf_nxt;
      end
      if (fire && emit_want) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire && emit_want) begin
      out_data_r.symbol          <= emit_sym;
      out_data_r.pool_overflowed <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ovf_flag  = ovf_r;

endmodule

`default_nettype wire

// ----- hdl/trie_root_replacer.sv -----
// Top level of the trie root replacer: front end with command queue and the
// trie back end. Depends on trp_pkg, trp_front and trp_back.
`default_nettype none

// Dictionary roots arrive as letters with a root_end mark and are built into a
// trie of NODES nodes; sentence letters are then echoed up to and including
// the letter that completes the shortest matching root, and the rest of that
// word is dropped. The front end takes a beat in every cycle while its
// 4-beat queue has room. The back end reads a child pointer from the
// single-port child memory, then acts on it and writes back, waiting while
// the result register is full; only then does it read the next item.
// After reset the child memory is cleared one entry a cycle, all of its
// NODES*ALPHABET entries (26624 by default); in_ready stays low meanwhile.
module trie_root_replacer #(
  parameter int NODES    = trp_pkg::NODES_DEF,
  parameter int ALPHABET = trp_pkg::ALPHABET_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire trp_pkg::trp_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output trp_pkg::trp_out_t      out_data
);
  import trp_pkg::*;

  trp_head_t head;
  logic      head_pop;
  logic      clr_busy;
  logic      ovf_flag;

  // Accept and decode beats into the command queue.
  trp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .accept_en (!clr_busy),
    .head      (head),
    .head_pop  (head_pop)
  );

  // Execute commands against the trie.
  trp_back #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_pop  (head_pop),
    .clr_busy  (clr_busy),
    .ovf_flag  (ovf_flag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // No beat is taken while the child memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !(in_valid && in_ready))
    else $error("input beat accepted during memory clear");

  // The back end pops only a valid queue head.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head.valid)
    else $error("queue popped while empty");

  // The overflow flag never clears outside reset.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(ovf_flag)) |-> ovf_flag)
    else $error("overflow flag cleared");
`endif

endmodule

`default_nettype wire
